// ----- hdl/xxh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xxh_pkg: shared definitions for the streaming XXH32 hasher
// Primes, datapath operation codes, and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package xxh_pkg;

  localparam logic [31:0] P1 = 32'h9E37_79B1;
  localparam logic [31:0] P2 = 32'h85EB_CA77;
  localparam logic [31:0] P3 = 32'hC2B2_AE3D;
  localparam logic [31:0] P4 = 32'h27D4_EB2F;
  localparam logic [31:0] P5 = 32'h1656_67B1;

  // One operation of the datapath per cycle; stripe and finalisation
  // operations never run in the same cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_S_MUL,    // prod = lane word * P2
    OP_S_ROT,    // acc  = rotl(lane + prod, 13)
    OP_S_MUL1,   // lane = acc * P1
    OP_F_SEED,   // acc  = seed + P5
    OP_F_M01,    // acc  = rotl(l0, 1) + rotl(l1, 7)
    OP_F_M2,     // acc += rotl(l2, 12)
    OP_F_M3,     // acc += rotl(l3, 18)
    OP_F_LEN,    // acc += message length
    OP_F_WMUL,   // prod = leftover word * P3
    OP_F_WROT,   // acc  = rotl(acc + prod, 17), drop the word
    OP_F_WMUL2,  // acc *= P4
    OP_F_BMUL,   // prod = leftover byte * P5
    OP_F_BROT,   // acc  = rotl(acc + prod, 11), drop the byte
    OP_F_BMUL2,  // acc *= P1
    OP_F_XS15,
    OP_F_AMUL2,
    OP_F_XS13,
    OP_F_AMUL3,
    OP_F_XS16    // final shift-xor into the output register
  } dp_op_t;

  typedef struct packed {
    logic       take;      // input transfer this cycle
    logic       launch;    // the current byte completes a stripe
    dp_op_t     op;
    logic [1:0] lane_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic fill_last;   // stripe buffer holds fifteen bytes
    logic words_left;  // at least four leftover bytes to fold
    logic bytes_left;  // any leftover byte to fold
    logic fin_seen;    // the finishing message completed a stripe
  } dp_sts_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned amt);
    return (x << amt) | (x >> (32 - amt));
  endfunction

endpackage
`default_nettype wire

// ----- hdl/xxh_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xxh_ctrl: controller for the XXH32 hasher
// Runs the stripe round sequencer alongside byte intake, and the
// finalisation state machine that folds leftovers and applies the avalanche.
// ----------------------------------------------------------------------------
module xxh_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_byte_valid,
  input  wire logic              in_last,
  input  wire logic              out_ready,
  input  wire xxh_pkg::dp_sts_t  sts,
  output logic                   in_ready,
  output logic                   out_valid,
  output xxh_pkg::ctl_cmd_t      cmd
);
  import xxh_pkg::*;

  typedef enum logic [4:0] {
    ST_RUN, ST_DRAIN, ST_START, ST_M2, ST_M3, ST_LEN,
    ST_WMUL, ST_WROT, ST_WMUL2, ST_BMUL, ST_BROT, ST_BMUL2,
    ST_XS15, ST_AMUL2, ST_XS13, ST_AMUL3, ST_XS16
  } state_t;

  typedef enum logic [1:0] {PH_MUL, PH_ROT, PH_MUL1} phase_t;

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] lane_r, lane_nxt;
  logic       out_valid_r, out_valid_nxt;
  dp_op_t     stripe_op;
  state_t     fold_next;

  assign in_ready  = (state_r == ST_RUN);
  assign out_valid = out_valid_r;

  always_comb begin
    stripe_op = OP_NONE;
    if (busy_r) begin
      case (phase_r)
        PH_MUL:  stripe_op = OP_S_MUL;
        PH_ROT:  stripe_op = OP_S_ROT;
        PH_MUL1: stripe_op = OP_S_MUL1;
        default: stripe_op = OP_NONE;
      endcase
    end
  end

  // Next fold step once the length is in or a previous fold has finished.
  always_comb begin
    if (sts.words_left) begin
      fold_next = ST_WMUL;
    end else if (sts.bytes_left) begin
      fold_next = ST_BMUL;
    end else begin
      fold_next = ST_XS15;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    busy_nxt      = busy_r;
    lane_nxt      = lane_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd.take      = in_valid & in_ready;
    cmd.launch    = in_valid & in_ready & in_byte_valid & sts.fill_last;
    cmd.lane_sel  = lane_r;
    cmd.op        = OP_NONE;

    // Stripe round: three steps per lane, four lanes.
    if (busy_r) begin
      case (phase_r)
        PH_MUL:  phase_nxt = PH_ROT;
        PH_ROT:  phase_nxt = PH_MUL1;
        default: begin
          phase_nxt = PH_MUL;
          lane_nxt  = lane_r + 2'd1;
          if (lane_r == 2'd3) begin
            busy_nxt = 1'b0;
          end
        end
      endcase
    end
    if (cmd.launch) begin
      busy_nxt  = 1'b1;
      lane_nxt  = 2'd0;
      phase_nxt = PH_MUL;
    end

    case (state_r)
      ST_RUN: begin
        cmd.op = stripe_op;
        if (cmd.take && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.op = stripe_op;
        if (!busy_r) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.op    = sts.fin_seen ? OP_F_M01 : OP_F_SEED;
        state_nxt = sts.fin_seen ? ST_M2 : ST_LEN;
      end
      ST_M2: begin
        cmd.op    = OP_F_M2;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        cmd.op    = OP_F_M3;
        state_nxt = ST_LEN;
      end
      ST_LEN: begin
        cmd.op    = OP_F_LEN;
        state_nxt = fold_next;
      end
      ST_WMUL: begin
        cmd.op    = OP_F_WMUL;
        state_nxt = ST_WROT;
      end
      ST_WROT: begin
        cmd.op    = OP_F_WROT;
        state_nxt = ST_WMUL2;
      end
      ST_WMUL2: begin
        cmd.op    = OP_F_WMUL2;
        state_nxt = fold_next;
      end
      ST_BMUL: begin
        cmd.op    = OP_F_BMUL;
        state_nxt = ST_BROT;
      end
      ST_BROT: begin
        cmd.op    = OP_F_BROT;
        state_nxt = ST_BMUL2;
      end
      ST_BMUL2: begin
        cmd.op    = OP_F_BMUL2;
        state_nxt = fold_next;
      end
      ST_XS15: begin
        cmd.op    = OP_F_XS15;
        state_nxt = ST_AMUL2;
      end
      ST_AMUL2: begin
        cmd.op    = OP_F_AMUL2;
        state_nxt = ST_XS13;
      end
      ST_XS13: begin
        cmd.op    = OP_F_XS13;
        state_nxt = ST_AMUL3;
      end
      ST_AMUL3: begin
        cmd.op    = OP_F_AMUL3;
        state_nxt = ST_XS16;
      end
      ST_XS16: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_F_XS16;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      phase_r     <= PH_MUL;
      busy_r      <= 1'b0;
      lane_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      busy_r      <= busy_nxt;
      lane_r      <= lane_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/xxh_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xxh_datapath: storage and arithmetic for the XXH32 hasher
// Stripe buffer, lane accumulators, one shared 32-bit multiplier and the
// finalisation accumulator, all driven by the controller's commands.
// ----------------------------------------------------------------------------
module xxh_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_byte_valid,
  input  wire logic               in_last,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire xxh_pkg::ctl_cmd_t  cmd,
  output xxh_pkg::dp_sts_t        sts,
  output logic [31:0]             out_hash_value
);
  import xxh_pkg::*;

  logic [31:0]        seed_r;
  logic [15:0][7:0]   buf_r;
  logic [15:0][7:0]   buf_app;
  logic [3:0]         fill_r;
  logic [31:0]        len_r;
  logic               seen_r;
  logic [3:0][31:0]   stripe_r;
  logic [3:0][31:0]   lane_r;
  logic [127:0]       fin_buf_r;
  logic [3:0]         fin_cnt_r;
  logic [31:0]        fin_len_r;
  logic               fin_seen_r;
  logic [31:0]        prod_r;
  logic [31:0]        acc_r;
  logic [31:0]        hash_r;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [31:0]        mul_p;
  logic               take_byte;
  logic               take_last;

  assign take_byte = cmd.take & in_byte_valid;
  assign take_last = cmd.take & in_last;

  always_comb begin
    buf_app = buf_r;
    if (in_byte_valid) begin
      buf_app[fill_r] = in_data_byte;
    end
  end

  always_comb begin
    case (cmd.op)
      OP_S_MUL: begin
        mul_a = stripe_r[cmd.lane_sel];
        mul_b = P2;
      end
      OP_F_WMUL: begin
        mul_a = fin_buf_r[31:0];
        mul_b = P3;
      end
      OP_F_WMUL2: begin
        mul_a = acc_r;
        mul_b = P4;
      end
      OP_F_BMUL: begin
        mul_a = {24'd0, fin_buf_r[7:0]};
        mul_b = P5;
      end
      OP_F_AMUL2: begin
        mul_a = acc_r;
        mul_b = P2;
      end
      OP_F_AMUL3: begin
        mul_a = acc_r;
        mul_b = P3;
      end
      default: begin
        mul_a = acc_r;
        mul_b = P1;
      end
    endcase
  end

  // Low 32 bits of the product only.
  assign mul_p = mul_a * mul_b;

  // Control state. A transfer that ends a message clears the message state
  // and captures what the finish needs; otherwise bytes count up and the
  // leftover count runs down during the fold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= '0;
      fill_r     <= '0;
      len_r      <= '0;
      seen_r     <= 1'b0;
      fin_cnt_r  <= '0;
      fin_seen_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (take_last) begin
        fill_r     <= '0;
        len_r      <= '0;
        seen_r     <= 1'b0;
        fin_cnt_r  <= fill_r + {3'd0, in_byte_valid};
        fin_seen_r <= seen_r | cmd.launch;
      end else begin
        if (take_byte) begin
          fill_r <= fill_r + 4'd1;
          len_r  <= len_r + 32'd1;
        end
        if (cmd.launch) begin
          seen_r <= 1'b1;
        end
        if (cmd.op == OP_F_WROT) begin
          fin_cnt_r <= fin_cnt_r - 4'd4;
        end else if (cmd.op == OP_F_BROT) begin
          fin_cnt_r <= fin_cnt_r - 4'd1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take_byte) begin
      buf_r[fill_r] <= in_data_byte;
    end
    if (cmd.launch) begin
      stripe_r <= buf_app;
    end
    if (take_last) begin
      fin_buf_r <= buf_app;
      fin_len_r <= len_r + {31'd0, in_byte_valid};
    end
    if (cmd.launch && !seen_r) begin
      lane_r[0] <= seed_r + P1 + P2;
      lane_r[1] <= seed_r + P2;
      lane_r[2] <= seed_r;
      lane_r[3] <= seed_r - P1;
    end
    case (cmd.op)
      OP_S_MUL:   prod_r <= mul_p;
      OP_S_ROT:   acc_r  <= rotl32(lane_r[cmd.lane_sel] + prod_r, 13);
      OP_S_MUL1:  lane_r[cmd.lane_sel] <= mul_p;
      OP_F_SEED:  acc_r  <= seed_r + P5;
      OP_F_M01:   acc_r  <= rotl32(lane_r[0], 1) + rotl32(lane_r[1], 7);
      OP_F_M2:    acc_r  <= acc_r + rotl32(lane_r[2], 12);
      OP_F_M3:    acc_r  <= acc_r + rotl32(lane_r[3], 18);
      OP_F_LEN:   acc_r  <= acc_r + fin_len_r;
      OP_F_WMUL:  prod_r <= mul_p;
      OP_F_WROT: begin
        acc_r     <= rotl32(acc_r + prod_r, 17);
        fin_buf_r <= fin_buf_r >> 32;
      end
      OP_F_WMUL2: acc_r  <= mul_p;
      OP_F_BMUL:  prod_r <= mul_p;
      OP_F_BROT: begin
        acc_r     <= rotl32(acc_r + prod_r, 11);
        fin_buf_r <= fin_buf_r >> 8;
      end
      OP_F_BMUL2: acc_r  <= mul_p;
      OP_F_XS15:  acc_r  <= acc_r ^ (acc_r >> 15);
      OP_F_AMUL2: acc_r  <= mul_p;
      OP_F_XS13:  acc_r  <= acc_r ^ (acc_r >> 13);
      OP_F_AMUL3: acc_r  <= mul_p;
      OP_F_XS16:  hash_r <= acc_r ^ (acc_r >> 16);
      default: ;
    endcase
  end

  assign sts.fill_last  = (fill_r == 4'd15);
  assign sts.words_left = |fin_cnt_r[3:2];
  assign sts.bytes_left = |fin_cnt_r;
  assign sts.fin_seen   = fin_seen_r;

  assign out_hash_value = hash_r;

endmodule
`default_nettype wire

// ----- hdl/xxhash32_stream_hasher.sv -----
`default_nettype none
// Finish: after a last transfer the hash waits for any stripe round still
//   running, then the lane merge when a stripe completed, the length, the
//   leftover word and byte folds, the avalanche and any wait for the previous hash to be taken.
// Throughput: one byte per cycle within a message; intake pauses from the
//   last transfer until the hash is loaded into the output register.
// Reset: synchronous, active low; clears the seed to zero and the message state.
// ----------------------------------------------------------------------------
// xxhash32_stream_hasher: streaming 32-bit xxHash with a configurable seed
// Bytes are gathered into 16-byte stripes. Each full stripe is copied into a
// stripe register and mixed into the four lane accumulators by a shared
// multiplier, while the next bytes keep arriving. On the transfer marked
// last, the controller waits for any round in flight, then merges the lanes
// (or starts from seed plus P5), adds the length, folds the leftover words
// and bytes and runs the avalanche, one step per cycle while the output is free.
// ----------------------------------------------------------------------------
module xxhash32_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_valid,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_hash_value,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);
  import xxh_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // The controller owns sequencing and both handshakes; the hash itself
  // lives in the output register of the datapath.
  xxh_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_byte_valid (in_byte_valid),
    .in_last       (in_last),
    .out_ready     (out_ready),
    .sts           (dp_sts),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .cmd           (ctl_cmd)
  );

  xxh_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data_byte   (in_data_byte),
    .in_byte_valid  (in_byte_valid),
    .in_last        (in_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (ctl_cmd),
    .sts            (dp_sts),
    .out_hash_value (out_hash_value)
  );

  // A transfer that ends a message always pauses intake for finalisation.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("intake not paused after the last transfer of a message");

  // Any other transfer leaves intake open.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_last) |=> in_ready)
    else $error("intake stalled inside a message");

  // Completing a stripe empties the stripe buffer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_byte_valid && dp_sts.fill_last) |=> !dp_sts.fill_last)
    else $error("stripe buffer not emptied after a full stripe");

endmodule
`default_nettype wire
